/* src/dxt1_pkg.sv */
// Shared types and constants for the DXT1 block decoder.
package dxt1_pkg;

  // Output format codes held in the format register.
  localparam logic FmtRgb565   = 1'b0;
  localparam logic FmtRgba8888 = 1'b1;

  // Default depth of the block queue between front and back.
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [15:0] endpoint_zero;
    logic [15:0] endpoint_one;
    logic [31:0] index_bits;
  } blk_t;

  typedef struct packed {
    logic [31:0] pixel_value;
    logic [1:0]  pixel_column;
    logic [1:0]  pixel_row;
    logic        last_pixel;
  } pix_t;

  typedef struct packed {
    logic output_format;
  } cfg_t;

  // One decoded block waiting in the queue: four palette colors and the codes.
  typedef struct packed {
    logic [3:0][31:0] palette;
    logic [31:0]      index_bits;
  } qent_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_status_t;

endpackage

/* src/dxt1_stream_if.sv */
// Valid/ready channel carrying one payload item per handshake.
interface dxt1_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* src/dxt1_block_decoder_unit.sv */
// Top level of the DXT1 block decoder: format register, front, queue and back.
//
//   channel   direction  payload                                   items
//   blk_in    in         endpoint_zero, endpoint_one, index_bits   one block
//   cfg_in    in         output_format                             one register write
//   pix_out   out        pixel_value, pixel_column, pixel_row,     one pixel, 16 per block
//                        last_pixel
//
// A block yields sixteen pixels at one per cycle unless pix_out stalls; the output
// pixel register of the back part sets that rate.
// The palette is built in the cycle a block is accepted and written into the queue;
// at the head of the queue, its pixels load into the output pixel register in turn.
// Reset empties the queue and the pixel register and sets the format to RGBA8888.
// A stalled pix_out freezes the back part; the queue holds up to QDepth blocks, the one
// being walked included, then blk_in.ready drops. cfg_in is always ready.
module dxt1_block_decoder_unit #(
  parameter int unsigned QDepth = dxt1_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  dxt1_stream_if.sink   blk_in,
  dxt1_stream_if.sink   cfg_in,
  dxt1_stream_if.source pix_out
);
  import dxt1_pkg::*;

  logic      fmt_q, fmt_d;
  logic      q_push;
  logic      q_pop;
  qent_t     q_entry;
  qent_t     q_head;
  q_status_t q_status;
  blk_t      blk_data;
  pix_t      pix_data;

  assign cfg_in.ready = 1'b1;
  assign fmt_d        = (cfg_in.valid) ? cfg_in.payload.output_format : fmt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FmtRgba8888;
    end else begin
      fmt_q <= fmt_d;
    end
  end

  assign blk_data.endpoint_zero = blk_in.payload.endpoint_zero;
  assign blk_data.endpoint_one  = blk_in.payload.endpoint_one;
  assign blk_data.index_bits    = blk_in.payload.index_bits;

  dxt1_palette_front u_front (
    .blk_valid_i (blk_in.valid),
    .blk_i       (blk_data),
    .blk_ready_o (blk_in.ready),
    .fmt_i       (fmt_q),
    .q_full_i    (q_status.full),
    .q_push_o    (q_push),
    .q_entry_o   (q_entry)
  );

  dxt1_block_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .entry_i  (q_entry),
    .pop_i    (q_pop),
    .head_o   (q_head),
    .status_o (q_status)
  );

  dxt1_pixel_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .head_i      (q_head),
    .pop_o       (q_pop),
    .pix_valid_o (pix_out.valid),
    .pix_o       (pix_data),
    .pix_ready_i (pix_out.ready)
  );

  assign pix_out.payload.pixel_value  = pix_data.pixel_value;
  assign pix_out.payload.pixel_column = pix_data.pixel_column;
  assign pix_out.payload.pixel_row    = pix_data.pixel_row;
  assign pix_out.payload.last_pixel   = pix_data.last_pixel;

`ifndef SYNTHESIS
  // The last pixel of a block must sit in the bottom-right corner.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_out.valid && pix_data.last_pixel) |->
      (pix_data.pixel_column == 2'd3 && pix_data.pixel_row == 2'd3))
    else $error("last pixel flagged away from the block corner");

  // Retiring a block from the queue loads its flagged last pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> (pix_out.valid && pix_data.last_pixel))
    else $error("block retired without its last pixel");

  // The back part never retires a block from an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_status.not_empty)
    else $error("pop from an empty block queue");
`endif

endmodule

/* src/dxt1_palette_front.sv */
// Front part: accepts a block and builds its four-entry palette.
module dxt1_palette_front (
  input  logic              blk_valid_i,
  input  dxt1_pkg::blk_t    blk_i,
  output logic              blk_ready_o,
  input  logic              fmt_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output dxt1_pkg::qent_t   q_entry_o
);
  import dxt1_pkg::*;

  localparam logic [10:0] Recip3 = 11'd683;

  // floor(x / 3) for x below 768, by multiplying with 683 / 2048.
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] prod;
    prod = {11'b0, x} * {10'b0, Recip3};
    return prod[18:11];
  endfunction

  function automatic logic [31:0] pack_color(input logic fmt, input logic [2:0][7:0] ch);
    logic [31:0] res;
    if (fmt == FmtRgba8888) begin
      res = {ch[2], ch[1], ch[0], 8'hFF};
    end else begin
      res = {16'b0, ch[2][4:0], ch[1][5:0], ch[0][4:0]};
    end
    return res;
  endfunction

  logic [2:0][7:0] c0_ch, c1_ch;
  logic [2:0][7:0] mix_a, mix_b, mix_h;
  logic [2:0][9:0] sum_a, sum_b;
  logic [2:0][8:0] sum_h;
  logic            four_color;

  // Channels are kept 8 bits wide; in RGB565 mode they hold the raw 5/6-bit values.
  always_comb begin
    if (fmt_i == FmtRgba8888) begin
      c0_ch[2] = {blk_i.endpoint_zero[15:11], 3'b0};
      c0_ch[1] = {blk_i.endpoint_zero[10:5], 2'b0};
      c0_ch[0] = {blk_i.endpoint_zero[4:0], 3'b0};
      c1_ch[2] = {blk_i.endpoint_one[15:11], 3'b0};
      c1_ch[1] = {blk_i.endpoint_one[10:5], 2'b0};
      c1_ch[0] = {blk_i.endpoint_one[4:0], 3'b0};
    end else begin
      c0_ch[2] = {3'b0, blk_i.endpoint_zero[15:11]};
      c0_ch[1] = {2'b0, blk_i.endpoint_zero[10:5]};
      c0_ch[0] = {3'b0, blk_i.endpoint_zero[4:0]};
      c1_ch[2] = {3'b0, blk_i.endpoint_one[15:11]};
      c1_ch[1] = {2'b0, blk_i.endpoint_one[10:5]};
      c1_ch[0] = {3'b0, blk_i.endpoint_one[4:0]};
    end
    for (int k = 0; k < 3; k++) begin
      sum_a[k] = {1'b0, c0_ch[k], 1'b0} + {2'b0, c1_ch[k]};
      sum_b[k] = {1'b0, c1_ch[k], 1'b0} + {2'b0, c0_ch[k]};
      sum_h[k] = {1'b0, c0_ch[k]} + {1'b0, c1_ch[k]};
      mix_a[k] = div3(sum_a[k]);
      mix_b[k] = div3(sum_b[k]);
      mix_h[k] = sum_h[k][8:1];
    end
  end

  assign four_color = blk_i.endpoint_zero > blk_i.endpoint_one;

  always_comb begin
    q_entry_o.index_bits = blk_i.index_bits;
    q_entry_o.palette[0] = pack_color(fmt_i, c0_ch);
    q_entry_o.palette[1] = pack_color(fmt_i, c1_ch);
    if (four_color) begin
      q_entry_o.palette[2] = pack_color(fmt_i, mix_a);
      q_entry_o.palette[3] = pack_color(fmt_i, mix_b);
    end else begin
      // Three-color blocks: the fourth entry is all zeros (transparent black in RGBA8888).
      q_entry_o.palette[2] = pack_color(fmt_i, mix_h);
      q_entry_o.palette[3] = '0;
    end
  end

  assign blk_ready_o = !q_full_i;
  assign q_push_o    = blk_valid_i && !q_full_i;

endmodule

/* src/dxt1_block_queue.sv */
// Short queue of decoded palettes between the front and back parts.
module dxt1_block_queue #(
  parameter int unsigned Depth = dxt1_pkg::QueueDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  dxt1_pkg::qent_t       entry_i,
  input  logic                  pop_i,
  output dxt1_pkg::qent_t       head_o,
  output dxt1_pkg::q_status_t   status_o
);
  import dxt1_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  qent_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  assign head_o             = mem_q[rd_ptr_q];
  assign status_o.not_empty = count_q != '0;
  assign status_o.full      = count_q == FullCnt;

endmodule

/* src/dxt1_pixel_back.sv */
// Back part: walks the sixteen pixels of the head block into the output register.
module dxt1_pixel_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dxt1_pkg::q_status_t   q_status_i,
  input  dxt1_pkg::qent_t       head_i,
  output logic                  pop_o,
  output logic                  pix_valid_o,
  output dxt1_pkg::pix_t        pix_o,
  input  logic                  pix_ready_i
);
  import dxt1_pkg::*;

  logic [3:0]       cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  pix_t             out_q, out_d;
  logic [15:0][1:0] codes;
  logic             advance;
  logic             last;

  assign codes   = head_i.index_bits;
  assign last    = cnt_q == 4'hF;
  // A new pixel loads whenever the queue holds a block and the output register is free or being drained.
  assign advance = q_status_i.not_empty && (!out_valid_q || pix_ready_i);
  assign pop_o   = advance && last;

  always_comb begin
    cnt_d       = cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      cnt_d              = cnt_q + 1'b1;
      out_d.pixel_value  = head_i.palette[codes[cnt_q]];
      out_d.pixel_column = cnt_q[1:0];
      out_d.pixel_row    = cnt_q[3:2];
      out_d.last_pixel   = last;
      out_valid_d        = 1'b1;
    end else if (pix_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign pix_valid_o = out_valid_q;
  assign pix_o       = out_q;

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the DXT1 block decoder: block stimulus, pixel prediction and checks.
`timescale 1ns / 100ps

module tb_top;
  import dxt1_pkg::*;

  localparam int unsigned HoldCycles = 200;
  localparam int unsigned StallLimit = 1500;
  localparam int unsigned TailCycles = 20;

  typedef enum logic [1:0] {
    RxAlways,
    RxMostly,
    RxSparse,
    RxPattern
  } rx_mode_e;

  // Holds the pixels each accepted block should produce, in order.
  class pixel_scoreboard;
    pix_t        pending_q[$];
    logic        format_sel = FmtRgba8888;
    int unsigned mismatches = 0;
    int unsigned pixels_checked = 0;

    function logic [31:0] mix_channel(int unsigned a, int unsigned b, int unsigned w,
                                      int unsigned d);
      return (w * a + b) / d;
    endfunction

    function logic [31:0] blend565(logic [15:0] c0, logic [15:0] c1, int unsigned w,
                                   int unsigned d);
      logic [31:0] r, g, bl;
      r  = mix_channel(c0[15:11], c1[15:11], w, d);
      g  = mix_channel(c0[10:5], c1[10:5], w, d);
      bl = mix_channel(c0[4:0], c1[4:0], w, d);
      return {16'h0000, r[4:0], g[5:0], bl[4:0]};
    endfunction

    // Zero-fill each channel into the top of its byte; alpha is opaque.
    function logic [31:0] widen565(logic [15:0] c);
      return {c[15:11], 3'b000, c[10:5], 2'b00, c[4:0], 3'b000, 8'hFF};
    endfunction

    function logic [31:0] blend8888(logic [31:0] c0, logic [31:0] c1, int unsigned w,
                                    int unsigned d);
      logic [31:0] res;
      logic [31:0] v;
      res = '0;
      for (int s = 0; s < 32; s += 8) begin
        v = mix_channel(c0[s+:8], c1[s+:8], w, d);
        res[s+:8] = v[7:0];
      end
      return res;
    endfunction

    function void note_block(blk_t blk);
      logic [31:0] palette [4];
      logic [31:0] c0, c1;
      logic        four_color;
      pix_t        px;
      four_color = blk.endpoint_zero > blk.endpoint_one;
      if (format_sel == FmtRgba8888) begin
        c0 = widen565(blk.endpoint_zero);
        c1 = widen565(blk.endpoint_one);
        palette[0] = c0;
        palette[1] = c1;
        palette[2] = four_color ? blend8888(c0, c1, 2, 3) : blend8888(c0, c1, 1, 2);
        palette[3] = four_color ? blend8888(c1, c0, 2, 3) : 32'h0;
      end else begin
        palette[0] = {16'h0000, blk.endpoint_zero};
        palette[1] = {16'h0000, blk.endpoint_one};
        palette[2] = four_color ? blend565(blk.endpoint_zero, blk.endpoint_one, 2, 3)
                                : blend565(blk.endpoint_zero, blk.endpoint_one, 1, 2);
        palette[3] = four_color ? blend565(blk.endpoint_one, blk.endpoint_zero, 2, 3)
                                : 32'h0;
      end
      for (int i = 0; i < 16; i++) begin
        px.pixel_value  = palette[blk.index_bits[2*i +: 2]];
        px.pixel_column = 2'(i);
        px.pixel_row    = 2'(i >> 2);
        px.last_pixel   = (i == 15);
        pending_q.push_back(px);
      end
    endfunction

    function void check_pixel(pix_t got);
      pix_t exp_px;
      pixels_checked++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected pixel value %h col %0d row %0d last %b", $time,
                   got.pixel_value, got.pixel_column, got.pixel_row, got.last_pixel);
        return;
      end
      exp_px = pending_q.pop_front();
      if (got.pixel_value !== exp_px.pixel_value || got.pixel_column !== exp_px.pixel_column ||
          got.pixel_row !== exp_px.pixel_row || got.last_pixel !== exp_px.last_pixel) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: pixel mismatch: expected %h col %0d row %0d last %b, got %h col %0d row %0d last %b",
                   $time, exp_px.pixel_value, exp_px.pixel_column, exp_px.pixel_row,
                   exp_px.last_pixel, got.pixel_value, got.pixel_column, got.pixel_row,
                   got.last_pixel);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  dxt1_stream_if #(.payload_t(blk_t)) blk_if ();
  dxt1_stream_if #(.payload_t(cfg_t)) cfg_if ();
  dxt1_stream_if #(.payload_t(pix_t)) pix_if ();

  dxt1_block_decoder_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .blk_in (blk_if),
    .cfg_in (cfg_if),
    .pix_out(pix_if)
  );

  pixel_scoreboard sb = new();

  rx_mode_e    rx_mode = RxAlways;
  logic        hold_off = 1'b0;
  int unsigned blocks_accepted = 0;
  int unsigned idle_cycles = 0;

  // Endpoint pairs and index words that hit the palette corners.
  logic [63:0] corner_blocks [12] = '{
    64'hFFFF_0000_E4E4E4E4,  // widest four-color block
    64'h0000_FFFF_E4E4E4E4,  // three-color block with transparent entry
    64'h8410_8410_FFFFFFFF,  // equal endpoints, every pixel transparent
    64'hFFFF_FFFF_1B1B1B1B,
    64'h0000_0000_E4E4E4E4,
    64'hF800_07E0_AAAAAAAA,
    64'h07E0_001F_55555555,
    64'h0001_0000_D8D8D8D8,  // endpoint zero just above endpoint one
    64'h0000_0001_27272727,
    64'hF81F_07E0_00000000,
    64'h001F_F800_FFFFFFFF,
    64'h7BEF_8430_0F0FF0F0
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready)
        sb.format_sel = cfg_if.payload.output_format;
      if (blk_if.valid && blk_if.ready) begin
        sb.note_block(blk_if.payload);
        blocks_accepted++;
      end
      if (pix_if.valid && pix_if.ready)
        sb.check_pixel(pix_if.payload);
    end
  end

  // Output side: a long hold-off on request, otherwise the current stall pattern.
  initial begin
    int unsigned rx_tick;
    rx_tick = 0;
    pix_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      rx_tick++;
      if (hold_off) begin
        hold_off = 1'b0;
        pix_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        pix_if.ready <= 1'b1;
      end else begin
        case (rx_mode)
          RxAlways:  pix_if.ready <= 1'b1;
          RxMostly:  pix_if.ready <= ($urandom_range(0, 3) != 0);
          RxSparse:  pix_if.ready <= ($urandom_range(0, 9) < 3);
          RxPattern: pix_if.ready <= ((rx_tick % 7) < 4);
          default:   pix_if.ready <= 1'b1;
        endcase
      end
    end
  end

  initial begin
    while (idle_cycles < StallLimit) begin
      @(posedge clk);
      if ((blk_if.valid && blk_if.ready) || (cfg_if.valid && cfg_if.ready) ||
          (pix_if.valid && pix_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Timeout: no item moved for %0d cycles", StallLimit);
    $display("Verification failed");
    $finish;
  end

  task automatic send_block(blk_t blk);
    blk_if.valid   <= 1'b1;
    blk_if.payload <= blk;
    @(posedge clk);
    while (!blk_if.ready) @(posedge clk);
  endtask

  task automatic pause_sender(int unsigned cycles);
    blk_if.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stop offering blocks and let every predicted pixel come out.
  task automatic drain_pixels();
    blk_if.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_format(logic fmt);
    cfg_if.valid                 <= 1'b1;
    cfg_if.payload.output_format <= fmt;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_corners(int unsigned max_gap);
    for (int i = 0; i < 12; i++) begin
      send_block(blk_t'(corner_blocks[i]));
      if (max_gap != 0 && $urandom_range(0, 1) != 0)
        pause_sender($urandom_range(1, max_gap));
    end
  endtask

  function automatic blk_t random_block();
    blk_t blk;
    blk.endpoint_zero = 16'($urandom);
    blk.endpoint_one  = ($urandom_range(0, 7) == 0) ? blk.endpoint_zero : 16'($urandom);
    blk.index_bits    = $urandom;
    return blk;
  endfunction

  // Bursts of random length separated by random gaps; max_gap of zero sends back to back.
  task automatic send_random(int unsigned count, int unsigned max_gap);
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 10);
      for (int unsigned k = 0; k < burst && sent < count; k++) begin
        send_block(random_block());
        sent++;
      end
      gap = $urandom_range(0, max_gap);
      if (gap != 0) pause_sender(gap);
    end
  endtask

  initial begin
    blk_if.valid   = 1'b0;
    blk_if.payload = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.payload = '0;
    rst_n          = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Corner blocks in the reset format, then in RGB565.
    rx_mode = RxAlways;
    send_corners(2);
    drain_pixels();
    write_format(FmtRgb565);
    rx_mode = RxMostly;
    send_corners(3);
    drain_pixels();

    write_format(FmtRgba8888);
    send_random(80, 6);
    drain_pixels();

    // Output held off while blocks keep coming, so the input side must stall.
    rx_mode  = RxAlways;
    hold_off = 1'b1;
    send_random(30, 0);
    drain_pixels();

    write_format(FmtRgb565);
    rx_mode = RxSparse;
    send_random(80, 4);
    drain_pixels();

    write_format(FmtRgba8888);
    rx_mode = RxPattern;
    send_random(60, 8);
    drain_pixels();

    write_format(FmtRgb565);
    rx_mode = RxAlways;
    send_random(50, 0);
    drain_pixels();

    repeat (TailCycles) @(posedge clk);
    $display("Covered %0d blocks and %0d pixels in both output formats,", blocks_accepted,
             sb.pixels_checked);
    $display("with random stalls on both sides and one long output hold-off.");
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d pixels still expected", sb.mismatches,
               sb.pending_q.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
src/dxt1_pkg.sv
src/dxt1_stream_if.sv
src/dxt1_palette_front.sv
src/dxt1_block_queue.sv
src/dxt1_pixel_back.sv
src/dxt1_block_decoder_unit.sv
dv/tb_top.sv
